// ----- design/swdh_pkg.sv -----
// ----------------------------------------------------------------------------
// SWD host package
// Shared types and codes of the serial wire debug host transaction engine.
// ----------------------------------------------------------------------------
package swdh_pkg;

  // Command codes carried on the input channel's tuser.
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_READ      = 3'd1;
  localparam logic [2:0] CMD_WRITE     = 3'd2;
  localparam logic [2:0] CMD_RESET     = 3'd3;
  localparam logic [2:0] CMD_RESET_IDL = 3'd4;

  // Outcome codes carried on the result channel's tuser.
  localparam logic [2:0] OC_NONE       = 3'd0;
  localparam logic [2:0] OC_OK         = 3'd1;
  localparam logic [2:0] OC_ACK_FAULT  = 3'd2;
  localparam logic [2:0] OC_PARITY_ERR = 3'd3;
  localparam logic [2:0] OC_RESET_DONE = 3'd4;

  localparam logic [2:0] ACK_OK        = 3'd1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RESET_HIGH = 2'd0;
  localparam logic [1:0] CFG_RESET_IDLE = 2'd1;
  localparam logic [1:0] CFG_TRAIL_IDLE = 2'd2;

  localparam logic [7:0] RESET_HIGH_DEF = 8'd60;
  localparam logic [3:0] RESET_IDLE_DEF = 4'd4;
  localparam logic [3:0] TRAIL_IDLE_DEF = 4'd8;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic [7:0] reset_high;
    logic [3:0] reset_idle;
    logic [3:0] trail_idle;
  } swdh_cfg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic        ap_not_dp;
    logic [1:0]  reg_addr;
    logic [31:0] write_data;
    logic        swdio_in;
  } swdh_item_t;

  typedef struct packed {
    logic        swdio_out;
    logic        swdio_drive;
    logic        clock_pulse;
    logic        busy;
    logic        done;
    logic [2:0]  ack_value;
    logic [31:0] read_data;
    logic [2:0]  outcome;
  } swdh_result_t;

endpackage

// ----- design/swdh_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// SWD host configuration registers
// Holds the line reset and trailing idle cycle counts written by software.
// ----------------------------------------------------------------------------
module swdh_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output swdh_pkg::swdh_cfg_t cfg
);

  swdh_pkg::swdh_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_high <= swdh_pkg::RESET_HIGH_DEF;
      cfg_r.reset_idle <= swdh_pkg::RESET_IDLE_DEF;
      cfg_r.trail_idle <= swdh_pkg::TRAIL_IDLE_DEF;
    end else if (cfg_valid) begin
      case (cfg_index)
        swdh_pkg::CFG_RESET_HIGH: cfg_r.reset_high <= cfg_data;
        swdh_pkg::CFG_RESET_IDLE: cfg_r.reset_idle <= cfg_data[3:0];
        swdh_pkg::CFG_TRAIL_IDLE: cfg_r.trail_idle <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/swdh_bit_engine.sv -----
// ----------------------------------------------------------------------------
// SWD host bit engine
// Sequencer for one SWCLK cycle per step: request, turnaround, ack, data,
// parity, trailing idle and line reset phases.
// ----------------------------------------------------------------------------
module swdh_bit_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  swdh_pkg::swdh_item_t   item,
  input  swdh_pkg::swdh_cfg_t    cfg,
  output swdh_pkg::swdh_result_t res
);

  typedef enum logic [9:0] {
    PH_IDLE  = 10'b00_0000_0001,
    PH_REQ   = 10'b00_0000_0010,
    PH_TURN1 = 10'b00_0000_0100,
    PH_ACK   = 10'b00_0000_1000,
    PH_TURN2 = 10'b00_0001_0000,
    PH_DATA  = 10'b00_0010_0000,
    PH_PAR   = 10'b00_0100_0000,
    PH_TRAIL = 10'b00_1000_0000,
    PH_RHIGH = 10'b01_0000_0000,
    PH_RIDLE = 10'b10_0000_0000
  } phase_t;

  phase_t      phase_r, phase_nxt, ph_e;
  logic [7:0]  cnt_r, cnt_nxt, cnt_e, cnt_inc, hi_cycles;
  logic [31:0] shift_r, shift_nxt, shift_e;
  logic [7:0]  req_r, req_nxt, req_e;
  logic [2:0]  ack_r, ack_nxt, ack_e;
  logic        wr_r, wr_nxt, wr_e;
  logic        widle_r, widle_nxt, widle_e;
  logic        lvl_r, lvl_nxt, drv_r, drv_nxt;
  logic        start_rw, start_rst;
  logic        lvl, drv, done, active;
  logic [2:0]  oc;
  logic        parity;

  // Request byte LSB first: start, APnDP, RnW, A2, A3, parity, stop, park.
  function automatic logic [7:0] build_request(input logic ap, input logic rd,
                                               input logic [1:0] a);
    logic [7:0] r;
    r = 8'h81;
    if (ap) r = r ^ 8'h22;
    if (rd) r = r ^ 8'h24;
    r = r | ({3'b000, a, 3'b000} & 8'h18);
    if (a == 2'd1 || a == 2'd2) r = r ^ 8'h20;
    return r;
  endfunction

  always_comb begin
    start_rw  = (phase_r == PH_IDLE) &&
                (item.command == swdh_pkg::CMD_READ || item.command == swdh_pkg::CMD_WRITE);
    start_rst = (phase_r == PH_IDLE) &&
                (item.command == swdh_pkg::CMD_RESET ||
                 item.command == swdh_pkg::CMD_RESET_IDL);

    // A command taken in idle runs its first cycle in the same step.
    ph_e    = phase_r;
    cnt_e   = cnt_r;
    shift_e = shift_r;
    req_e   = req_r;
    ack_e   = ack_r;
    wr_e    = wr_r;
    widle_e = widle_r;
    if (start_rw) begin
      wr_e    = (item.command == swdh_pkg::CMD_WRITE);
      req_e   = build_request(item.ap_not_dp, !wr_e, item.reg_addr);
      shift_e = wr_e ? item.write_data : 32'd0;
      ack_e   = 3'd0;
      cnt_e   = 8'd0;
      ph_e    = PH_REQ;
    end else if (start_rst) begin
      widle_e = (item.command == swdh_pkg::CMD_RESET_IDL);
      cnt_e   = 8'd0;
      ph_e    = PH_RHIGH;
    end

    phase_nxt = ph_e;
    cnt_nxt   = cnt_e;
    shift_nxt = shift_e;
    req_nxt   = req_e;
    ack_nxt   = ack_e;
    wr_nxt    = wr_e;
    widle_nxt = widle_e;
    cnt_inc   = cnt_e + 8'd1;
    hi_cycles = (cfg.reset_high == 8'd0) ? 8'd1 : cfg.reset_high;
    parity    = ^shift_e;
    lvl       = 1'b0;
    drv       = 1'b1;
    done      = 1'b0;
    oc        = swdh_pkg::OC_NONE;
    active    = 1'b1;

    case (ph_e)
      PH_REQ: begin
        lvl     = req_e[cnt_e[2:0]];
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 8'd8) begin
          phase_nxt = PH_TURN1;
          cnt_nxt   = 8'd0;
        end
      end
      PH_TURN1: begin
        lvl       = 1'b1;
        phase_nxt = PH_ACK;
        cnt_nxt   = 8'd0;
      end
      PH_ACK: begin
        drv     = 1'b0;
        ack_nxt = ack_e | ({2'b00, item.swdio_in} << cnt_e[1:0]);
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 8'd3) begin
          cnt_nxt = 8'd0;
          if (wr_e) begin
            phase_nxt = PH_TURN2;
          end else if (ack_nxt != swdh_pkg::ACK_OK) begin
            done = 1'b1;
            oc   = swdh_pkg::OC_ACK_FAULT;
          end else begin
            phase_nxt = PH_DATA;
            shift_nxt = 32'd0;
          end
        end
      end
      PH_TURN2: begin
        lvl     = 1'b1;
        cnt_nxt = 8'd0;
        if (ack_e != swdh_pkg::ACK_OK) begin
          done = 1'b1;
          oc   = swdh_pkg::OC_ACK_FAULT;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (wr_e) begin
          lvl = shift_e[cnt_e[4:0]];
        end else begin
          drv       = 1'b0;
          shift_nxt = shift_e | ({31'd0, item.swdio_in} << cnt_e[4:0]);
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 8'd32) begin
          phase_nxt = PH_PAR;
          cnt_nxt   = 8'd0;
        end
      end
      PH_PAR: begin
        if (wr_e) begin
          lvl = parity;
        end else begin
          drv = 1'b0;
        end
        if (!wr_e && item.swdio_in != parity) begin
          done = 1'b1;
          oc   = swdh_pkg::OC_PARITY_ERR;
        end else begin
          cnt_nxt = 8'd0;
          if (cfg.trail_idle == 4'd0) begin
            done = 1'b1;
            oc   = swdh_pkg::OC_OK;
          end else begin
            phase_nxt = PH_TRAIL;
          end
        end
      end
      PH_TRAIL: begin
        lvl     = 1'b0;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= {4'd0, cfg.trail_idle}) begin
          done = 1'b1;
          oc   = swdh_pkg::OC_OK;
        end
      end
      PH_RHIGH: begin
        lvl     = 1'b1;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= hi_cycles) begin
          cnt_nxt = 8'd0;
          if (widle_e && cfg.reset_idle != 4'd0) begin
            phase_nxt = PH_RIDLE;
          end else begin
            done = 1'b1;
            oc   = swdh_pkg::OC_RESET_DONE;
          end
        end
      end
      PH_RIDLE: begin
        lvl     = 1'b0;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= {4'd0, cfg.reset_idle}) begin
          done = 1'b1;
          oc   = swdh_pkg::OC_RESET_DONE;
        end
      end
      default: begin
        // Idle with no command: the line keeps whatever the last command left.
        active    = 1'b0;
        phase_nxt = PH_IDLE;
        lvl       = drv_r & lvl_r;
        drv       = drv_r;
      end
    endcase

    if (!drv) lvl = 1'b0;

    lvl_nxt = lvl;
    drv_nxt = drv;
    res.swdio_out   = lvl;
    res.swdio_drive = drv;
    res.clock_pulse = active;
    res.busy        = active;
    res.done        = done;
    res.ack_value   = 3'd0;
    res.read_data   = 32'd0;
    res.outcome     = oc;
    if (done) begin
      if (oc == swdh_pkg::OC_RESET_DONE) begin
        lvl_nxt = 1'b1;
      end else begin
        res.ack_value = ack_nxt;
      end
      if (oc == swdh_pkg::OC_OK && !wr_e) res.read_data = shift_nxt;
      phase_nxt = PH_IDLE;
      cnt_nxt   = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= 8'd0;
      shift_r <= 32'd0;
      req_r   <= 8'd0;
      ack_r   <= 3'd0;
      wr_r    <= 1'b0;
      widle_r <= 1'b0;
      lvl_r   <= 1'b1;
      drv_r   <= 1'b1;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      req_r   <= req_nxt;
      ack_r   <= ack_nxt;
      wr_r    <= wr_nxt;
      widle_r <= widle_nxt;
      lvl_r   <= lvl_nxt;
      drv_r   <= drv_nxt;
    end
  end

endmodule

// ----- design/swd_host_transaction_engine.sv -----
// ----------------------------------------------------------------------------
// SWD host transaction engine
// Serial wire debug host sequencer, one SWCLK bit cycle per stream transaction.
// ----------------------------------------------------------------------------
// Each input transaction stands for one SWCLK cycle. It carries the sampled
// SWDIO level and, when the engine is idle, a command (read, write, line
// reset, line reset with idle). Each input transaction gives exactly one
// result transaction: the level and drive enable for SWDIO, the clock
// enable, busy, and on the last cycle of a command (tlast) the ack bits,
// the read word and the outcome code on tuser.
// The input is captured in a register, the bit sequencer works on it
// combinationally and writes the output register, so a result passes the input
// and output registers. One transaction per clock is sustained while the receiver
// does not stall; the phase counter of the sequencer is updated once per transaction.
// When the receiver stalls, the output register holds its result and the
// input register fills, after which in_tready falls; nothing is lost.
// Configuration writes are taken at any time and should be issued only while
// no command is in progress. After reset the pipeline is empty, the engine is
// idle with the line driven high, and the registers hold their defaults: reset high 60,
// reset idle 4 and trailing idle 8.
module swd_host_transaction_engine (
  input  logic        clk,
  input  logic        rst_n,
  // Input: ap_not_dp[0], reg_addr[2:1], write_data[34:3], swdio_in[35], zero fill
  input  logic [39:0] in_tdata,
  // Input tuser: command[2:0]
  input  logic [2:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Result: swdio_out[0], swdio_drive[1], clock_pulse[2], busy_res[3],
  // ack_value[6:4], read_data[38:7], zero fill
  output logic [39:0] out_tdata,
  // Result tuser: outcome[2:0]
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  swdh_pkg::swdh_cfg_t    cfg;
  swdh_pkg::swdh_item_t   item_r;
  swdh_pkg::swdh_result_t res, res_r;
  logic                   in_valid_r, out_valid_r;
  logic                   advance, step_en;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign step_en   = in_valid_r && advance;

  swdh_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  swdh_bit_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.command    <= in_tuser;
      item_r.ap_not_dp  <= in_tdata[0];
      item_r.reg_addr   <= in_tdata[2:1];
      item_r.write_data <= in_tdata[34:3];
      item_r.swdio_in   <= in_tdata[35];
    end
    if (step_en) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.read_data, res_r.ack_value, res_r.busy,
                       res_r.clock_pulse, res_r.swdio_drive, res_r.swdio_out};
  assign out_tuser  = res_r.outcome;
  assign out_tlast  = res_r.done;

endmodule

// ----- design/swdh_checker.sv -----
// ----------------------------------------------------------------------------
// SWD host port checker
// Watches the result channel of the transaction engine for consistency.
// ----------------------------------------------------------------------------
module swdh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast,
  input logic        out_tvalid,
  input logic        out_tready
);

  // A stalled result must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // An outcome is reported exactly on the last cycle of a command.
  a_last_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser != swdh_pkg::OC_NONE) == out_tlast))
    else $error("outcome and last flag disagree");

  // The last cycle of a command is always a clocked, busy cycle.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[2] && out_tdata[3])
    else $error("last cycle without clock or busy");

  // A released line is reported as low.
  a_released_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> !out_tdata[0])
    else $error("released line shows a high level");

  // Read data appears only with a successful outcome.
  a_rdata_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[38:7] != 32'd0 |-> out_tuser == swdh_pkg::OC_OK)
    else $error("read data without a successful outcome");

endmodule

bind swd_host_transaction_engine swdh_checker u_swdh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

// ----- test/swd_host_transaction_engine_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SWD host transaction engine checker
// Watches the input, result and register channels of the engine, keeps its
// own model of the bit sequencer and compares every result transaction with
// the cycle it predicted.
// ----------------------------------------------------------------------------
module swd_host_transaction_engine_checker
  import swdh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [39:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          failures,
  output int          pending,
  output int          results_checked,
  output int          ok_seen,
  output int          fault_seen,
  output int          parity_seen,
  output int          reset_seen
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_REQUEST, ST_TURN1, ST_ACK, ST_TURN2, ST_DATA, ST_PARITY,
    ST_TRAIL, ST_LINE_HIGH, ST_LINE_IDLE
  } line_phase_t;

  line_phase_t  st;
  logic [7:0]   bit_cnt;
  logic [31:0]  word;
  logic [7:0]   request;
  logic [2:0]   ack_bits;
  logic         is_write;
  logic         with_idle;
  logic         line_level;
  logic         line_driven;
  logic [7:0]   reg_high;
  logic [3:0]   reg_idle;
  logic [3:0]   reg_trail;

  swdh_result_t expected_cycles [$];

  // Advances the sequencer by one SWCLK cycle and returns what the engine
  // should present for it.
  function automatic swdh_result_t next_line_cycle(input swdh_item_t it);
    swdh_result_t r;
    logic         lvl;
    logic         drv;
    logic         fin;
    logic         level_after;
    logic         rnw;
    logic [2:0]   oc;
    logic [7:0]   high_len;
    r = '0;
    lvl = 1'b0;
    drv = 1'b1;
    fin = 1'b0;
    oc = OC_NONE;
    high_len = (reg_high == 8'd0) ? 8'd1 : reg_high;
    if (st == ST_IDLE) begin
      if (it.command == CMD_READ || it.command == CMD_WRITE) begin
        is_write = (it.command == CMD_WRITE);
        rnw = !is_write;
        // Start, APnDP, RnW, A2, A3, even parity, stop, park.
        request = {1'b1, 1'b0, it.ap_not_dp ^ rnw ^ it.reg_addr[0] ^ it.reg_addr[1],
                   it.reg_addr[1], it.reg_addr[0], rnw, it.ap_not_dp, 1'b1};
        word = is_write ? it.write_data : 32'd0;
        ack_bits = 3'd0;
        bit_cnt = 8'd0;
        st = ST_REQUEST;
      end else if (it.command == CMD_RESET || it.command == CMD_RESET_IDL) begin
        with_idle = (it.command == CMD_RESET_IDL);
        bit_cnt = 8'd0;
        st = ST_LINE_HIGH;
      end else begin
        r.swdio_out = line_driven & line_level;
        r.swdio_drive = line_driven;
        return r;
      end
    end
    case (st)
      ST_REQUEST: begin
        lvl = request[bit_cnt[2:0]];
        bit_cnt = bit_cnt + 8'd1;
        if (bit_cnt >= 8'd8) begin
          st = ST_TURN1;
          bit_cnt = 8'd0;
        end
      end
      ST_TURN1: begin
        lvl = 1'b1;
        st = ST_ACK;
        bit_cnt = 8'd0;
      end
      ST_ACK: begin
        drv = 1'b0;
        if (it.swdio_in) ack_bits[bit_cnt[1:0]] = 1'b1;
        bit_cnt = bit_cnt + 8'd1;
        if (bit_cnt >= 8'd3) begin
          bit_cnt = 8'd0;
          if (is_write) begin
            st = ST_TURN2;
          end else if (ack_bits != ACK_OK) begin
            fin = 1'b1;
            oc = OC_ACK_FAULT;
          end else begin
            st = ST_DATA;
            word = 32'd0;
          end
        end
      end
      ST_TURN2: begin
        lvl = 1'b1;
        bit_cnt = 8'd0;
        if (ack_bits != ACK_OK) begin
          fin = 1'b1;
          oc = OC_ACK_FAULT;
        end else begin
          st = ST_DATA;
        end
      end
      ST_DATA: begin
        if (is_write) begin
          lvl = word[bit_cnt[4:0]];
        end else begin
          drv = 1'b0;
          if (it.swdio_in) word[bit_cnt[4:0]] = 1'b1;
        end
        bit_cnt = bit_cnt + 8'd1;
        if (bit_cnt >= 8'd32) begin
          st = ST_PARITY;
          bit_cnt = 8'd0;
        end
      end
      ST_PARITY: begin
        if (is_write) lvl = ^word;
        else drv = 1'b0;
        if (!is_write && it.swdio_in != ^word) begin
          fin = 1'b1;
          oc = OC_PARITY_ERR;
        end else begin
          bit_cnt = 8'd0;
          if (reg_trail == 4'd0) begin
            fin = 1'b1;
            oc = OC_OK;
          end else begin
            st = ST_TRAIL;
          end
        end
      end
      ST_TRAIL: begin
        lvl = 1'b0;
        bit_cnt = bit_cnt + 8'd1;
        if (bit_cnt >= {4'd0, reg_trail}) begin
          fin = 1'b1;
          oc = OC_OK;
        end
      end
      ST_LINE_HIGH: begin
        lvl = 1'b1;
        bit_cnt = bit_cnt + 8'd1;
        if (bit_cnt >= high_len) begin
          bit_cnt = 8'd0;
          if (with_idle && reg_idle != 4'd0) begin
            st = ST_LINE_IDLE;
          end else begin
            fin = 1'b1;
            oc = OC_RESET_DONE;
          end
        end
      end
      ST_LINE_IDLE: begin
        lvl = 1'b0;
        bit_cnt = bit_cnt + 8'd1;
        if (bit_cnt >= {4'd0, reg_idle}) begin
          fin = 1'b1;
          oc = OC_RESET_DONE;
        end
      end
      default: ;
    endcase
    if (!drv) lvl = 1'b0;
    level_after = lvl;
    if (fin) begin
      // A line reset always leaves the line high, even after its idle part.
      if (oc != OC_RESET_DONE) r.ack_value = ack_bits;
      else level_after = 1'b1;
      if (oc == OC_OK && !is_write) r.read_data = word;
      st = ST_IDLE;
      bit_cnt = 8'd0;
    end
    line_level = level_after;
    line_driven = drv;
    r.swdio_out = lvl;
    r.swdio_drive = drv;
    r.clock_pulse = 1'b1;
    r.busy = 1'b1;
    r.done = fin;
    r.outcome = oc;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : observe
    swdh_item_t   it;
    swdh_result_t want;
    if (!rst_n) begin
      st = ST_IDLE;
      bit_cnt = 8'd0;
      word = 32'd0;
      request = 8'd0;
      ack_bits = 3'd0;
      is_write = 1'b0;
      with_idle = 1'b0;
      line_level = 1'b1;
      line_driven = 1'b1;
      reg_high = RESET_HIGH_DEF;
      reg_idle = RESET_IDLE_DEF;
      reg_trail = TRAIL_IDLE_DEF;
      expected_cycles.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RESET_HIGH: reg_high = cfg_data;
          CFG_RESET_IDLE: reg_idle = cfg_data[3:0];
          CFG_TRAIL_IDLE: reg_trail = cfg_data[3:0];
          default: ;
        endcase
      end
      // Results are taken before new inputs so that a stray result is never
      // matched against an expectation pushed on the same edge.
      if (out_tvalid && out_tready) begin
        if (expected_cycles.size() == 0) begin
          $error("result transaction with no expected cycle: tdata 0x%0h, tuser %0d",
                 out_tdata, out_tuser);
          failures++;
        end else begin
          want = expected_cycles.pop_front();
          check_field("swdio_out", want.swdio_out, out_tdata[0]);
          check_field("swdio_drive", want.swdio_drive, out_tdata[1]);
          check_field("clock_pulse", want.clock_pulse, out_tdata[2]);
          check_field("busy_res", want.busy, out_tdata[3]);
          check_field("ack_value", want.ack_value, out_tdata[6:4]);
          check_field("read_data", want.read_data, out_tdata[38:7]);
          check_field("tdata fill", 32'd0, out_tdata[39]);
          check_field("done_res", want.done, out_tlast);
          check_field("outcome", want.outcome, out_tuser);
          results_checked++;
          case (want.outcome)
            OC_OK: ok_seen++;
            OC_ACK_FAULT: fault_seen++;
            OC_PARITY_ERR: parity_seen++;
            OC_RESET_DONE: reset_seen++;
            default: ;
          endcase
        end
      end
      if (in_tvalid && in_tready) begin
        it.command = in_tuser;
        it.ap_not_dp = in_tdata[0];
        it.reg_addr = in_tdata[2:1];
        it.write_data = in_tdata[34:3];
        it.swdio_in = in_tdata[35];
        expected_cycles.push_back(next_line_cycle(it));
      end
    end
    pending <= expected_cycles.size();
  end

endmodule

// ----- test/swd_host_transaction_engine_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SWD host transaction engine testbench
// Feeds SWCLK bit cycles that form reads, writes and line resets with
// chosen ack, data and parity bits, under changing register settings and
// idling on both channels; the checker beside the engine judges every result.
// ----------------------------------------------------------------------------
module swd_host_transaction_engine_test;
  import swdh_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 180;

  // Ack patterns a target may return besides OK.
  localparam logic [2:0] ACK_WAIT  = 3'd2;
  localparam logic [2:0] ACK_FAULT = 3'd4;
  localparam logic [2:0] ACK_NONE  = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = CMD_NONE;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_RESET_HIGH;
  logic [7:0]  cfg_data = '0;

  int failures;
  int pending;
  int results_checked;
  int ok_seen;
  int fault_seen;
  int parity_seen;
  int reset_seen;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_taken = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int sent_items = 0;
  int noise_items = 0;
  int reg_writes = 0;

  logic [7:0] high_now = RESET_HIGH_DEF;
  logic [3:0] idle_now = RESET_IDLE_DEF;
  logic [3:0] trail_now = TRAIL_IDLE_DEF;

  swd_host_transaction_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  swd_host_transaction_engine_checker bit_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .failures        (failures),
    .pending         (pending),
    .results_checked (results_checked),
    .ok_seen         (ok_seen),
    .fault_seen      (fault_seen),
    .parity_seen     (parity_seen),
    .reset_seen      (reset_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one has been requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_taken != holds_asked) begin
      holds_taken <= holds_taken + 1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("No transaction for %0d cycles.", QUIET_LIMIT);
    $display("** swd_host_transaction_engine: FAILED **");
    $finish;
  end

  task automatic send_item(input logic [2:0] cmd, input logic ap, input logic [1:0] addr,
                           input logic [31:0] wdata, input logic sin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= {4'd0, sin, wdata, addr, ap};
    in_tuser <= cmd;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
  endtask

  // A cycle in the middle of a command: everything but the line level is noise.
  task automatic send_filler(input logic sin);
    send_item(3'($urandom_range(7)), 1'($urandom), 2'($urandom), $urandom, sin);
  endtask

  task automatic send_noise(input int count);
    logic [2:0] cmd;
    repeat (count) begin
      cmd = $urandom_range(1) ? CMD_NONE : 3'($urandom_range(int'(CMD_RESET_IDL) + 1, 7));
      send_item(cmd, 1'($urandom), 2'($urandom), $urandom, 1'($urandom));
      noise_items++;
    end
  endtask

  task automatic run_access(input logic wr, input logic ap, input logic [1:0] addr,
                            input logic [31:0] word, input logic [2:0] ack,
                            input logic parity_good);
    send_item(wr ? CMD_WRITE : CMD_READ, ap, addr, word, 1'($urandom));
    // Rest of the request and the first turnaround.
    repeat (8) send_filler(1'($urandom));
    for (int k = 0; k < 3; k++) send_filler(ack[k]);
    if (wr) send_filler(1'($urandom));
    if (ack == ACK_OK) begin
      for (int k = 0; k < 32; k++) send_filler(wr ? 1'($urandom) : word[k]);
      send_filler(wr ? 1'($urandom) : ((^word) ^ !parity_good));
      if (wr || parity_good) repeat (trail_now) send_filler(1'($urandom));
    end
  endtask

  task automatic run_line_reset(input logic idle_after);
    int len;
    len = (high_now == 8'd0) ? 1 : int'(high_now);
    if (idle_after) len += idle_now;
    send_item(idle_after ? CMD_RESET_IDL : CMD_RESET, 1'($urandom), 2'($urandom),
              $urandom, 1'($urandom));
    repeat (len - 1) send_filler(1'($urandom));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] high, input logic [3:0] idle,
                              input logic [3:0] trail);
    logic [1:0] idx  [3];
    logic [7:0] vals [3];
    idx  = '{CFG_RESET_HIGH, CFG_RESET_IDLE, CFG_TRAIL_IDLE};
    vals = '{high, {4'd0, idle}, {4'd0, trail}};
    for (int k = 0; k < 3; k++) begin
      cfg_index <= idx[k];
      cfg_data <= vals[k];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    high_now = high;
    idle_now = idle;
    trail_now = trail;
    reg_writes += 3;
  endtask

  initial begin : stimulus
    int          goal;
    int          pick;
    logic [31:0] word;
    logic [2:0]  ack;
    logic        hold_done;
    logic        pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every zero-length special case first.
    program_regs(8'd0, 4'd0, 4'd0);
    send_item(CMD_NONE, 1'b1, 2'd3, '1, 1'b1);
    for (int c = int'(CMD_RESET_IDL) + 1; c < 8; c++)
      send_item(3'(c), 1'b0, 2'd0, '0, 1'b0);
    run_access(1'b0, 1'b0, 2'd0, '1, ACK_OK, 1'b1);
    run_access(1'b1, 1'b1, 2'd3, '1, ACK_OK, 1'b1);
    run_access(1'b1, 1'b0, 2'd1, '0, ACK_OK, 1'b1);
    run_access(1'b0, 1'b1, 2'd2, '0, ACK_OK, 1'b0);
    run_access(1'b0, 1'b0, 2'd1, 32'h1234_5678, ACK_WAIT, 1'b1);
    run_access(1'b1, 1'b1, 2'd0, 32'h8765_4321, ACK_FAULT, 1'b1);
    run_access(1'b0, 1'b0, 2'd3, $urandom, ACK_NONE, 1'b1);
    run_line_reset(1'b0);
    run_line_reset(1'b1);
    drain();
    program_regs(8'd255, 4'd15, 4'd15);
    run_line_reset(1'b1);
    run_line_reset(1'b0);
    run_access(1'b0, 1'b1, 2'd1, $urandom, ACK_OK, 1'b1);
    run_access(1'b1, 1'b0, 2'd2, $urandom, ACK_OK, 1'b1);

    // Random part in four idling phases, each under fresh register values.
    for (int p = 0; p < 4; p++) begin
      drain();
      send_idle_pct = (p == 1) ? 69 : (p == 3) ? 32 : 0;
      stall_pct <= (p == 2) ? 69 : (p == 3) ? 32 : 0;
      program_regs((p == 2) ? 8'd50 : 8'($urandom_range(50, 72)),
                   4'($urandom_range(2, 15)), 4'($urandom_range(15)));
      goal = sent_items - noise_items + PHASE_ITEMS;
      while (sent_items - noise_items < goal) begin
        if (p == 0 && !hold_done && sent_items - noise_items > goal - PHASE_ITEMS / 2) begin
          holds_asked <= holds_asked + 1;
          hold_done = 1'b1;
        end
        if (p == 1 && !pause_done && sent_items - noise_items > goal - PHASE_ITEMS / 2) begin
          drain();
          pause_done = 1'b1;
        end
        word = $urandom;
        case ($urandom_range(9))
          0: word = '0;
          1: word = '1;
          default: ;
        endcase
        ack = ACK_OK;
        if ($urandom_range(4) == 0) begin
          do ack = 3'($urandom); while (ack == ACK_OK);
        end
        pick = $urandom_range(99);
        if (pick < 8)
          send_noise($urandom_range(1, 4));
        else if (pick < 48)
          run_access(1'b0, 1'($urandom), 2'($urandom), word, ack, $urandom_range(6) != 0);
        else if (pick < 88)
          run_access(1'b1, 1'($urandom), 2'($urandom), word, ack, 1'b1);
        else
          run_line_reset(1'($urandom));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d SWCLK cycles: %0d completed accesses, %0d ack faults, %0d parity errors, %0d line resets.",
             results_checked, ok_seen, fault_seen, parity_seen, reset_seen);
    $display("Four idling phases, %0d register writes, %0d long receiver hold-off and sender pauses.",
             reg_writes, holds_asked);
    if (failures == 0 && pending == 0)
      $display("** swd_host_transaction_engine: PASSED **");
    else
      $display("** swd_host_transaction_engine: FAILED **");
    $finish;
  end

endmodule
